### rtl/trli_pkg.sv
// ----------------------------------------------------------------------------
// trli_pkg - shared types and constants of the track resampler
// Beat layouts, fixed-point widths and state encodings used by the top level
// and by the per-axis interpolation lane.
// ----------------------------------------------------------------------------
package trli_pkg;

    // fixed-point layout
    localparam int TIME_W    = 32;
    localparam int FRAC_BITS = 8;
    localparam int GRID_W    = TIME_W - FRAC_BITS;
    localparam int POS_W     = 24;
    localparam int GAP_W     = 8;
    localparam int DEN_W     = TIME_W + 1;
    localparam int MAG_W     = POS_W + 1;
    localparam int ITER_W    = $clog2(MAG_W);

    // reset value of the gap limit register, in whole seconds
    localparam logic [GAP_W-1:0] GAP_LIMIT_RST = GAP_W'(10);

    // -1.0 in coordinate format
    localparam logic signed [POS_W-1:0] NEG_ONE = POS_W'(-(2 ** FRAC_BITS));

    // input beat
    typedef struct packed {
        logic [TIME_W-1:0]       sample_time;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    track_start;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [GRID_W-1:0]       grid_time;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic                    in_gap;
        logic                    run_cut;
        logic                    last_of_run;
    } t_out_beat;

    // operands handed to one interpolation lane
    typedef struct packed {
        logic signed [POS_W-1:0] y1;
        logic signed [POS_W-1:0] y2;
        logic signed [DEN_W-1:0] num;
        logic signed [DEN_W-1:0] den;
    } t_lane_req;

    // top level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LAUNCH,
        S_CALC,
        S_OUT
    } t_state;

    // interpolation lane sequencer
    typedef enum logic [2:0] {
        L_IDLE,
        L_PREP,
        L_ITER,
        L_ROUND,
        L_FIN
    } t_lane_state;

endpackage

### rtl/trli_axis_div.sv
// ----------------------------------------------------------------------------
// trli_axis_div - one axis of the linear interpolation
// Computes y1 + round(dy * num / den) with num clamped to [0, den], feeding
// |dy| in one bit per cycle, MSB first, through a multiply-and-reduce loop
// that keeps a remainder below den and a quotient with digits 0..2.
// ----------------------------------------------------------------------------
module trli_axis_div
    import trli_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  t_lane_req               i_req,
    output logic                    o_done,
    output logic signed [POS_W-1:0] o_res
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAG_W - 1);

    t_lane_state r_state, n_state;

    logic signed [POS_W-1:0] r_y1;
    logic signed [POS_W-1:0] r_y2;
    logic signed [MAG_W-1:0] r_dy;
    logic [TIME_W-1:0]       r_den;
    logic [TIME_W-1:0]       r_num;
    logic                    r_take_y2;
    logic [MAG_W-1:0]        r_a;
    logic                    r_neg;
    logic [TIME_W-1:0]       r_rem;
    logic [MAG_W-1:0]        r_q;
    logic [ITER_W-1:0]       r_cnt;
    logic                    r_done;
    logic signed [POS_W-1:0] r_res;

    // load side: clamp of the segment parameter and the coordinate step
    logic                    ld_den_pos;
    logic [TIME_W-1:0]       ld_num;
    logic signed [MAG_W-1:0] ld_dy;

    // iteration side
    logic [TIME_W+1:0]       it_add;
    logic [TIME_W+1:0]       it_sum;
    logic [TIME_W+1:0]       it_den1;
    logic [TIME_W+1:0]       it_den2;
    logic [TIME_W+1:0]       it_rem;
    logic [1:0]              it_digit;
    logic [MAG_W:0]          it_q;

    // rounding and final sum
    logic [TIME_W:0]         rd_sum;
    logic                    rd_inc;
    logic signed [MAG_W:0]   fn_mag;
    logic signed [MAG_W:0]   fn_y1;
    logic signed [MAG_W:0]   fn_sum;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE:  if (i_start) n_state = L_PREP;
            L_PREP:  n_state = r_take_y2 ? L_FIN : L_ITER;
            L_ITER:  if (r_cnt == ITER_LAST) n_state = L_ROUND;
            L_ROUND: n_state = L_FIN;
            L_FIN:   n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    // operand load with clamp
    always_comb begin
        ld_den_pos = (i_req.den > $signed(DEN_W'(0)));
        if (i_req.num < $signed(DEN_W'(0))) begin
            ld_num = '0;
        end else if (i_req.num > i_req.den) begin
            ld_num = i_req.den[TIME_W-1:0];
        end else begin
            ld_num = i_req.num[TIME_W-1:0];
        end
        ld_dy = MAG_W'({i_req.y2[POS_W-1], i_req.y2}) - MAG_W'({i_req.y1[POS_W-1], i_req.y1});
    end

    // one multiply-and-reduce step: rem = 2*rem + bit*num, reduced below den
    always_comb begin
        it_add  = r_a[MAG_W-1] ? {2'b00, r_num} : '0;
        it_sum  = {1'b0, r_rem, 1'b0} + it_add;
        it_den1 = {2'b00, r_den};
        it_den2 = {1'b0, r_den, 1'b0};
        if (it_sum >= it_den2) begin
            it_rem   = it_sum - it_den2;
            it_digit = 2'd2;
        end else if (it_sum >= it_den1) begin
            it_rem   = it_sum - it_den1;
            it_digit = 2'd1;
        end else begin
            it_rem   = it_sum;
            it_digit = 2'd0;
        end
        it_q = {r_q, 1'b0} + {{(MAG_W-1){1'b0}}, it_digit};
    end

    // round half away from zero on the magnitude, then apply the sign
    always_comb begin
        rd_sum = {1'b0, r_rem} + {2'b00, r_den[TIME_W-1:1]};
        rd_inc = (rd_sum >= {1'b0, r_den});
        fn_mag = $signed({1'b0, r_q});
        fn_y1  = $signed({{2{r_y1[POS_W-1]}}, r_y1});
        fn_sum = r_neg ? (fn_y1 - fn_mag) : (fn_y1 + fn_mag);
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_y1      <= i_req.y1;
                    r_y2      <= i_req.y2;
                    r_dy      <= ld_dy;
                    r_den     <= i_req.den[TIME_W-1:0];
                    r_num     <= ld_num;
                    r_take_y2 <= !ld_den_pos;
                end
            end
            L_PREP: begin
                r_a   <= r_dy[MAG_W-1] ? MAG_W'(-r_dy) : MAG_W'(r_dy);
                r_neg <= r_dy[MAG_W-1];
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= '0;
            end
            L_ITER: begin
                r_rem <= it_rem[TIME_W-1:0];
                r_q   <= it_q[MAG_W-1:0];
                r_a   <= {r_a[MAG_W-2:0], 1'b0};
                r_cnt <= r_cnt + ITER_W'(1);
            end
            L_ROUND: begin
                r_q <= r_q + MAG_W'(rd_inc);
            end
            L_FIN: begin
                r_res <= r_take_y2 ? r_y2 : fn_sum[POS_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == L_FIN);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // magnitude of the coordinate step
    function automatic logic [MAG_W-1:0] step_mag();
        logic [MAG_W-1:0] v;
        v = r_dy[MAG_W-1] ? MAG_W'(-r_dy) : MAG_W'(r_dy);
        return v;
    endfunction

    // remainder stays reduced below the spacing while iterating
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_ITER && !r_take_y2) |-> (r_rem < r_den))
        else $error("lane remainder not below spacing");

    // rounded magnitude never exceeds the coordinate step
    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_FIN && !r_take_y2) |-> (r_q <= step_mag()))
        else $error("lane magnitude above step");

    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("lane done held");

endmodule

### rtl/track_resample_linear_interp_unit.sv
// ----------------------------------------------------------------------------
// track_resample_linear_interp_unit - resample a 3D track onto whole seconds
// Holds the previous sample and the next grid second, and for each later
// sample emits one interpolated (or gap-marked) point per grid second due.
// ----------------------------------------------------------------------------
// One sample is taken at a time; the input is stalled until every point it
// causes has been delivered. A sample that starts a track is absorbed in
// S_IDLE, and one that is due no grid second after S_CHECK. Each point is
// set up in S_CHECK and S_LAUNCH; an interpolated point then runs the lane
// load, a bit-serial multiply and reduce loop over the coordinate step (three
// axis lanes run side by side), rounding, and the lane result and its
// hand-back; every point ends with the output beat, which waits out any stall.
// Gap points skip the lanes. At most MAX_RUN points come from one sample; the
// last point of a sample carries last_of_run, and run_cut as well when more
// grid seconds were due and were dropped.
module track_resample_linear_interp_unit
    import trli_pkg::*;
#(
    parameter int MAX_RUN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [GAP_W-1:0] i_cfg_data,
    // sample beats
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_data,
    // point beats
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_data
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam logic [CNT_W-1:0] RUN_FULL = CNT_W'(MAX_RUN);

    t_state r_state, n_state;

    logic [GAP_W-1:0]        r_gap_limit;
    logic [TIME_W-1:0]       r_prev_t;
    logic signed [POS_W-1:0] r_prev_x;
    logic signed [POS_W-1:0] r_prev_y;
    logic signed [POS_W-1:0] r_prev_z;
    logic [GRID_W-1:0]       r_ngs;
    logic                    r_have_prev;

    logic [TIME_W-1:0]       r_cur_t;
    logic signed [POS_W-1:0] r_cur_x;
    logic signed [POS_W-1:0] r_cur_y;
    logic signed [POS_W-1:0] r_cur_z;
    logic signed [DEN_W-1:0] r_den;
    logic signed [DEN_W-1:0] r_num;
    logic [GRID_W-1:0]       r_g;
    logic [CNT_W-1:0]        r_n;
    logic                    r_gap;
    logic                    r_last;
    logic                    r_cut;
    t_out_beat               r_out;

    logic                    in_acc;
    logic                    out_acc;
    logic                    first_smp;
    logic [GRID_W-1:0]       in_after;
    logic [GRID_W-1:0]       cur_after;
    logic                    due;
    logic [GRID_W-1:0]       g_next;
    logic [CNT_W-1:0]        n_next;
    logic                    next_due;
    logic signed [DEN_W-1:0] gap_span;

    logic                    lane_start;
    t_lane_req               req_x, req_y, req_z;
    logic                    x_done, y_done, z_done;
    logic signed [POS_W-1:0] x_res, y_res, z_res;

    // handshake and grid bookkeeping
    always_comb begin
        in_acc    = i_in_valid && !o_in_stall;
        out_acc   = o_out_valid && !i_out_stall;
        first_smp = i_in_data.track_start || !r_have_prev;
        in_after  = i_in_data.sample_time[TIME_W-1:FRAC_BITS] + GRID_W'(1);
        cur_after = r_cur_t[TIME_W-1:FRAC_BITS] + GRID_W'(1);
        due       = (r_g <= r_cur_t[TIME_W-1:FRAC_BITS]);
        g_next    = r_g + GRID_W'(1);
        n_next    = r_n + CNT_W'(1);
        next_due  = (g_next <= r_cur_t[TIME_W-1:FRAC_BITS]);
        gap_span  = $signed({{(DEN_W-GAP_W-FRAC_BITS){1'b0}}, r_gap_limit,
                             {FRAC_BITS{1'b0}}});
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc && !first_smp) n_state = S_CHECK;
            S_CHECK:  n_state = due ? S_LAUNCH : S_IDLE;
            S_LAUNCH: n_state = r_gap ? S_OUT : S_CALC;
            S_CALC:   if (x_done) n_state = S_OUT;
            S_OUT: begin
                if (out_acc) begin
                    n_state = r_last ? S_IDLE : S_CHECK;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= GAP_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_gap_limit <= i_cfg_data;
        end
    end

    // held sample and grid position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_t    <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_ngs       <= '0;
            r_have_prev <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && first_smp) begin
                        r_prev_t    <= i_in_data.sample_time;
                        r_prev_x    <= i_in_data.pos_x;
                        r_prev_y    <= i_in_data.pos_y;
                        r_prev_z    <= i_in_data.pos_z;
                        r_ngs       <= in_after;
                        r_have_prev <= 1'b1;
                    end
                end
                S_CHECK: begin
                    if (!due) begin
                        r_prev_t <= r_cur_t;
                        r_prev_x <= r_cur_x;
                        r_prev_y <= r_cur_y;
                        r_prev_z <= r_cur_z;
                        r_ngs    <= r_g;
                    end
                end
                S_OUT: begin
                    if (out_acc && r_last) begin
                        r_prev_t <= r_cur_t;
                        r_prev_x <= r_cur_x;
                        r_prev_y <= r_cur_y;
                        r_prev_z <= r_cur_z;
                        r_ngs    <= r_cut ? cur_after : g_next;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // run datapath and output register
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_cur_t <= i_in_data.sample_time;
                    r_cur_x <= i_in_data.pos_x;
                    r_cur_y <= i_in_data.pos_y;
                    r_cur_z <= i_in_data.pos_z;
                    r_den   <= $signed({1'b0, i_in_data.sample_time})
                             - $signed({1'b0, r_prev_t});
                    r_g     <= r_ngs;
                    r_n     <= '0;
                end
            end
            S_CHECK: begin
                r_num  <= $signed({1'b0, r_g, {FRAC_BITS{1'b0}}})
                        - $signed({1'b0, r_prev_t});
                r_gap  <= (r_den > gap_span);
                r_last <= (n_next == RUN_FULL) || !next_due;
                r_cut  <= (n_next == RUN_FULL) && next_due;
            end
            S_LAUNCH: begin
                if (r_gap) begin
                    r_out.grid_time   <= r_g;
                    r_out.out_x       <= NEG_ONE;
                    r_out.out_y       <= NEG_ONE;
                    r_out.out_z       <= NEG_ONE;
                    r_out.in_gap      <= 1'b1;
                    r_out.run_cut     <= r_cut;
                    r_out.last_of_run <= r_last;
                end
            end
            S_CALC: begin
                if (x_done) begin
                    r_out.grid_time   <= r_g;
                    r_out.out_x       <= x_res;
                    r_out.out_y       <= y_res;
                    r_out.out_z       <= z_res;
                    r_out.in_gap      <= 1'b0;
                    r_out.run_cut     <= r_cut;
                    r_out.last_of_run <= r_last;
                end
            end
            S_OUT: begin
                if (out_acc && !r_last) begin
                    r_g <= g_next;
                    r_n <= n_next;
                end
            end
            default: begin
            end
        endcase
    end

    // axis lanes
    always_comb begin
        lane_start = (r_state == S_LAUNCH) && !r_gap;
        req_x = '{y1: r_prev_x, y2: r_cur_x, num: r_num, den: r_den};
        req_y = '{y1: r_prev_y, y2: r_cur_y, num: r_num, den: r_den};
        req_z = '{y1: r_prev_z, y2: r_cur_z, num: r_num, den: r_den};
    end

    trli_axis_div u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_req   (req_x),
        .o_done  (x_done),
        .o_res   (x_res)
    );

    trli_axis_div u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_req   (req_y),
        .o_done  (y_done),
        .o_res   (y_res)
    );

    trli_axis_div u_lane_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lane_start),
        .i_req   (req_z),
        .o_done  (z_done),
        .o_res   (z_res)
    );

    // ports
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    // the three lanes run in lock step
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (x_done == y_done) && (y_done == z_done))
        else $error("axis lanes out of step");

    // no sample taken while a point waits
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("sample taken with point pending");

    // run counter stays below the cap
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_n < RUN_FULL))
        else $error("run counter beyond cap");

    // a cut run ends on that point
    a_cut_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.run_cut) |-> o_out_data.last_of_run)
        else $error("run cut on inner point");

    // gap points carry -1.0 on every axis
    a_gap_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.in_gap) |->
            (o_out_data.out_x == NEG_ONE && o_out_data.out_y == NEG_ONE
             && o_out_data.out_z == NEG_ONE))
        else $error("gap point with coordinates");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the track resampler
// Feeds timestamped track samples through a valid/stall channel and checks
// every resampled point against a cycle-free predictor of the grid walk and
// the rounded linear interpolation, over several gap limit settings.
// ----------------------------------------------------------------------------
module tb;
    import trli_pkg::*;

    localparam int RUN_MAX        = 64;
    localparam int IDLE_PCT       = 23;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 5000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [GAP_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_beat         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_beat        o_out_data;

    // samples waiting to be driven, and points still owed by the block
    t_in_beat  sample_q[$];
    t_out_beat due_points[$];

    // predictor copy of the held sample, the grid and the register
    logic [TIME_W-1:0]       track_time;
    logic signed [POS_W-1:0] track_x, track_y, track_z;
    logic [GRID_W-1:0]       grid_next;
    bit                      track_held;
    logic [GAP_W-1:0]        gap_limit_m;

    int        samples_queued = 0;
    int        samples_taken = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        hold_left = 0;
    bit        hold_arm = 1'b0;
    bit        steady = 1'b0;
    bit        in_fire = 1'b0;
    t_out_beat want;

    track_resample_linear_interp_unit #(
        .MAX_RUN(RUN_MAX)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // y1 + round(dy * num / den), fraction clamped to [0, 1], ties away from zero
    function automatic logic signed [POS_W-1:0] lerp_axis(
        input logic signed [POS_W-1:0] y1,
        input logic signed [POS_W-1:0] y2,
        input longint num,
        input longint den
    );
        longint dy, p, mag;
        if (den <= 0) return y2;
        if (num < 0) num = 0;
        if (num > den) num = den;
        dy = longint'(y2) - longint'(y1);
        p = dy * num;
        mag = (p < 0) ? -p : p;
        mag = (mag + den / 2) / den;
        if (p < 0) mag = -mag;
        return POS_W'(longint'(y1) + mag);
    endfunction

    // walk the grid seconds due up to this sample and queue the points
    task automatic resample_sample(input t_in_beat b);
        logic [GRID_W-1:0] after, g;
        longint            den, num;
        bit                gap, cut;
        int                n;
        t_out_beat         pts[RUN_MAX];
        after = GRID_W'((b.sample_time >> FRAC_BITS) + 1);
        n = 0;
        cut = 1'b0;
        if (b.track_start || !track_held) begin
            grid_next = after;
        end else begin
            den = longint'(b.sample_time) - longint'(track_time);
            gap = den > (longint'(gap_limit_m) << FRAC_BITS);
            g = grid_next;
            while ({g, {FRAC_BITS{1'b0}}} <= b.sample_time) begin
                if (n >= RUN_MAX) begin
                    cut = 1'b1;
                    break;
                end
                pts[n] = '0;
                pts[n].grid_time = g;
                pts[n].in_gap = gap;
                if (gap) begin
                    pts[n].out_x = NEG_ONE;
                    pts[n].out_y = NEG_ONE;
                    pts[n].out_z = NEG_ONE;
                end else begin
                    num = longint'({g, {FRAC_BITS{1'b0}}}) - longint'(track_time);
                    pts[n].out_x = lerp_axis(track_x, b.pos_x, num, den);
                    pts[n].out_y = lerp_axis(track_y, b.pos_y, num, den);
                    pts[n].out_z = lerp_axis(track_z, b.pos_z, num, den);
                end
                n++;
                g = g + 1'b1;
            end
            // truncated run drops the rest and restarts after this sample
            if (cut) begin
                pts[n-1].run_cut = 1'b1;
                g = after;
            end
            if (n > 0) pts[n-1].last_of_run = 1'b1;
            grid_next = g;
            for (int k = 0; k < n; k++) due_points.insert(due_points.size(), pts[k]);
        end
        track_time = b.sample_time;
        track_x = b.pos_x;
        track_y = b.pos_y;
        track_z = b.pos_z;
        track_held = 1'b1;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // monitor: predictor updates, point checks and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            track_time = '0;
            track_x = '0;
            track_y = '0;
            track_z = '0;
            grid_next = '0;
            track_held = 1'b0;
            gap_limit_m = GAP_LIMIT_RST;
            in_fire = 1'b0;
            quiet_cycles = 0;
        end else begin
            if (i_cfg_we) gap_limit_m = i_cfg_data;
            in_fire = i_in_valid && !o_in_stall;
            if (in_fire) begin
                resample_sample(i_in_data);
                samples_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_points.size() == 0) begin
                    $error("unexpected point beat at grid_time %0d", o_out_data.grid_time);
                    mismatches++;
                end else begin
                    want = due_points.pop_front();
                    check_field("grid_time", want.grid_time, o_out_data.grid_time);
                    check_field("out_x", want.out_x, o_out_data.out_x);
                    check_field("out_y", want.out_y, o_out_data.out_y);
                    check_field("out_z", want.out_z, o_out_data.out_z);
                    check_field("in_gap", want.in_gap, o_out_data.in_gap);
                    check_field("run_cut", want.run_cut, o_out_data.run_cut);
                    check_field("last_of_run", want.last_of_run, o_out_data.last_of_run);
                end
                quiet_cycles = 0;
            end else if (in_fire) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // sample driver: a beat stays put until it is taken
    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (sample_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_data <= sample_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // point receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_arm) begin
            hold_arm = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic queue_sample(input logic [TIME_W-1:0] t, input logic signed [POS_W-1:0] x,
                                input logic signed [POS_W-1:0] y,
                                input logic signed [POS_W-1:0] z, input logic start);
        t_in_beat b;
        b.sample_time = t;
        b.pos_x = x;
        b.pos_y = y;
        b.pos_z = z;
        b.track_start = start;
        sample_q.insert(sample_q.size(), b);
        samples_queued++;
    endtask

    // one track: mostly rising samples, with gaps, long jumps and broken ordering
    task automatic push_track(input int samples, input int limit_s);
        logic [TIME_W-1:0]       t;
        logic signed [POS_W-1:0] x, y, z;
        logic                    start;
        int                      roll;
        t = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        z = POS_W'($urandom);
        queue_sample(t, x, y, z, 1'b1);
        for (int k = 1; k < samples; k++) begin
            roll = $urandom_range(99);
            start = 1'b0;
            if (roll < 55) t = t + $urandom_range(0, 768);
            else if (roll < 70) t = t + (limit_s << FRAC_BITS) - 1 + $urandom_range(0, 2);
            else if (roll < 82) t = t + $urandom_range(1024, 6000);
            else if (roll < 88) t = t - $urandom_range(1, 600);
            else if (roll < 92) t = t + $urandom_range(64 * 256, 80 * 256);
            else if (roll < 96) t = $urandom;
            else begin
                t = $urandom;
                start = 1'b1;
            end
            if ($urandom_range(9) == 0) begin
                x = POS_W'($urandom);
                y = POS_W'($urandom);
                z = POS_W'($urandom);
            end else begin
                x = x + POS_W'($urandom_range(0, 8191)) - POS_W'(4096);
                y = y + POS_W'($urandom_range(0, 8191)) - POS_W'(4096);
                z = z + POS_W'($urandom_range(0, 8191)) - POS_W'(4096);
            end
            queue_sample(t, x, y, z, start);
        end
    endtask

    task automatic push_tracks(input int count, input int limit_s);
        int n, len;
        n = 0;
        while (n < count) begin
            len = $urandom_range(3, 12);
            push_track(len, limit_s);
            n += len;
        end
    endtask

    // all samples taken, all points seen, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (samples_taken != samples_queued || due_points.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_gap_limit(input logic [GAP_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        logic [GAP_W-1:0] mid_limit;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset gap limit of 10 s
        // first sample with no held one, no start flag
        queue_sample(32'h0000_0100, '0, '0, '0, 1'b0);
        queue_sample(32'h0000_0280, 24'h7FFFFF, 24'h800000, 24'h123456, 1'b0);
        // no grid second due
        queue_sample(32'h0000_02C0, 24'h000010, 24'h000020, 24'h000030, 1'b0);
        // restart at zero, then half-way ties of both signs
        queue_sample(32'h0000_0000, '0, '0, '0, 1'b1);
        queue_sample(32'h0000_0200, 24'h000001, 24'hFFFFFF, 24'h000003, 1'b0);
        // spacing exactly at the limit, then just past it
        queue_sample(32'h0000_0C00, 24'h7FFFFF, 24'h800000, '0, 1'b0);
        queue_sample(32'h0000_1601, 24'h000100, 24'h000200, 24'h000300, 1'b0);
        // earlier than the held sample
        queue_sample(32'h0000_0800, 24'h001000, 24'hFFF000, 24'h000500, 1'b0);
        // long gap run gets cut
        queue_sample(32'h0000_6200, 24'h002000, 24'h000000, 24'hFFFF00, 1'b0);
        // grid wraps, then negative spacing, an interpolated run and zero spacing
        queue_sample(32'hFFFF_FE80, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
        queue_sample(32'hFFFF_FFFF, 24'h800000, 24'h800000, 24'h800000, 1'b0);
        queue_sample(32'h0000_0180, 24'h000100, 24'h000000, 24'hFFFF00, 1'b0);
        queue_sample(32'h0000_0380, 24'h7FFF00, 24'h800100, 24'h000055, 1'b0);
        queue_sample(32'h0000_0380, 24'h000001, 24'h000002, 24'h000003, 1'b0);
        wait_drained();

        // widest limit, no idling on either side
        write_gap_limit(8'd255);
        steady = 1'b1;
        push_tracks(25, 255);
        wait_drained();
        steady = 1'b0;

        // narrowest nonzero limit, receiver holds off while samples keep coming
        write_gap_limit(8'd1);
        hold_arm = 1'b1;
        push_tracks(25, 1);
        wait_drained();

        // zero limit: every positive spacing is a gap
        write_gap_limit(8'd0);
        push_tracks(25, 0);
        wait_drained();

        mid_limit = GAP_W'($urandom_range(2, 254));
        write_gap_limit(mid_limit);
        push_tracks(25, int'(mid_limit));
        wait_drained();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
